// ----- sv/ps2ht_pkg.sv -----
package ps2ht_pkg;

    // Command codes carried in the request's tuser.
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SEND = 2'd1,
        CMD_RECV = 2'd2,
        CMD_INIT = 2'd3
    } cmd_t;

    // Register indexes on the configuration port (byte address bit 2).
    typedef enum logic {
        REG_TIMEOUT = 1'b0,
        REG_INHIBIT = 1'b1
    } reg_idx_t;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_W_REL   = 5'd1,
        PH_W_INH   = 5'd2,
        PH_W_RTS   = 5'd3,
        PH_W_START = 5'd4,
        PH_W_BHI   = 5'd5,
        PH_W_BLO   = 5'd6,
        PH_W_PHI   = 5'd7,
        PH_W_PLO   = 5'd8,
        PH_W_SDLY  = 5'd9,
        PH_W_ACK   = 5'd10,
        PH_W_REL2  = 5'd11,
        PH_R_DLY   = 5'd12,
        PH_R_FIRST = 5'd13,
        PH_R_DLY5  = 5'd14,
        PH_R_SHI   = 5'd15,
        PH_R_BLO   = 5'd16,
        PH_R_BHI   = 5'd17,
        PH_R_T0    = 5'd18,
        PH_R_T1    = 5'd19,
        PH_R_T2    = 5'd20,
        PH_R_T3    = 5'd21,
        PH_I_DLY   = 5'd22
    } phase_t;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [11:0] INHIBIT_RESET = 12'd300;

    localparam logic [15:0] RTS_US        = 16'd10;
    localparam logic [15:0] TX_SETTLE_US  = 16'd50;
    localparam logic [15:0] RX_SETTLE_US  = 16'd50;
    localparam logic [15:0] RX_EDGE_US    = 16'd5;
    localparam logic [15:0] INIT_PAUSE_US = 16'd100;

    localparam logic [7:0] BYTE_RESET  = 8'hFF;
    localparam logic [7:0] BYTE_REMOTE = 8'hF0;

    localparam logic [2:0] INIT_STEP_REMOTE = 3'd4;
    localparam logic [2:0] INIT_STEP_PAUSE  = 3'd6;
    localparam logic [3:0] FRAME_BITS       = 4'd8;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] tx_byte;
        logic       clk_line;
        logic       data_line;
    } item_t;

    // Packed so that clk_drive_low lands in bit 0.
    typedef struct packed {
        logic       init_ok;
        logic       connected;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       data_drive_low;
        logic       clk_drive_low;
    } result_t;

endpackage

// ----- sv/ps2ht_core.sv -----
module ps2ht_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  ps2ht_pkg::item_t  item,
    input  logic [15:0]       timeout_us,
    input  logic [11:0]       inhibit_us,
    output ps2ht_pkg::result_t result
);
    import ps2ht_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic        parity_reg, parity_next;
    logic [15:0] wait_timer_reg, wait_timer_next;
    logic [2:0]  init_step_reg, init_step_next;
    logic        link_up_reg, link_up_next;
    logic        clk_low_reg, clk_low_next;
    logic        data_low_reg, data_low_next;
    logic        in_init_reg, in_init_next;
    logic [7:0]  rx_hold_reg, rx_hold_next;
    logic        init_ok_reg, init_ok_next;
    logic        done_next;

    logic [15:0] tmr_inc;
    logic [15:0] delay_limit;
    logic        is_delay, is_wait, wait_cond;
    logic        advance, abort_ev, sub_done_ev;
    logic        rx_phase, shared_tmr;
    logic [3:0]  bc_inc;
    logic [2:0]  init_inc;
    logic        parity_new;
    phase_t      sub_phase;

    assign tmr_inc  = wait_timer_reg + 16'd1;
    assign bc_inc   = bit_count_reg + 4'd1;
    assign init_inc = init_step_reg + 3'd1;
    assign parity_new = parity_reg ^ shift_reg[0];

    always_comb begin
        is_delay    = 1'b0;
        delay_limit = '0;
        case (phase_reg)
            PH_W_REL, PH_W_INH: begin
                is_delay    = 1'b1;
                delay_limit = {4'd0, inhibit_us};
            end
            PH_W_RTS: begin
                is_delay    = 1'b1;
                delay_limit = RTS_US;
            end
            PH_W_SDLY: begin
                is_delay    = 1'b1;
                delay_limit = TX_SETTLE_US;
            end
            PH_R_DLY: begin
                is_delay    = 1'b1;
                delay_limit = RX_SETTLE_US;
            end
            PH_R_DLY5: begin
                is_delay    = 1'b1;
                delay_limit = RX_EDGE_US;
            end
            PH_I_DLY: begin
                is_delay    = 1'b1;
                delay_limit = INIT_PAUSE_US;
            end
            default: ;
        endcase
    end

    always_comb begin
        is_wait   = 1'b1;
        wait_cond = 1'b0;
        case (phase_reg)
            PH_W_START, PH_W_BLO, PH_W_PLO, PH_W_ACK,
            PH_R_BLO, PH_R_T0, PH_R_T2:
                wait_cond = !item.clk_line;
            PH_W_BHI, PH_W_PHI, PH_R_SHI, PH_R_BHI, PH_R_T1, PH_R_T3:
                wait_cond = item.clk_line;
            PH_W_REL2:
                wait_cond = item.clk_line && item.data_line;
            default:
                is_wait = 1'b0;
        endcase
    end

    always_comb begin
        if (is_delay) begin
            advance = tmr_inc >= delay_limit;
        end else if (is_wait) begin
            advance = wait_cond;
        end else begin
            advance = (phase_reg == PH_R_FIRST) && !item.clk_line;
        end
    end

    assign abort_ev    = is_wait && !wait_cond && (tmr_inc >= timeout_us);
    assign sub_done_ev = advance && ((phase_reg == PH_W_REL2) || (phase_reg == PH_R_T3));
    assign rx_phase    = (phase_reg >= PH_R_DLY) && (phase_reg <= PH_R_T3);
    // The parity and stop edges of a receive run against one shared timer.
    assign shared_tmr  = (phase_reg == PH_R_T0) || (phase_reg == PH_R_T1) ||
                         (phase_reg == PH_R_T2);

    always_comb begin
        if (!in_init_reg) begin
            sub_phase = PH_IDLE;
        end else if (init_inc == INIT_STEP_REMOTE) begin
            sub_phase = PH_W_REL;
        end else if (init_inc >= INIT_STEP_PAUSE) begin
            sub_phase = PH_I_DLY;
        end else begin
            sub_phase = PH_R_DLY;
        end
    end

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (abort_ev) begin
            phase_next = PH_IDLE;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    case (item.mode)
                        CMD_SEND, CMD_INIT: phase_next = PH_W_REL;
                        CMD_RECV:           phase_next = PH_R_DLY;
                        default:            phase_next = PH_IDLE;
                    endcase
                end
                PH_W_REL:   if (advance) phase_next = PH_W_INH;
                PH_W_INH:   if (advance) phase_next = PH_W_RTS;
                PH_W_RTS:   if (advance) phase_next = PH_W_START;
                PH_W_START: if (advance) phase_next = PH_W_BHI;
                PH_W_BHI:   if (advance) phase_next = PH_W_BLO;
                PH_W_BLO: begin
                    if (advance) phase_next = (bc_inc >= FRAME_BITS) ? PH_W_PHI : PH_W_BHI;
                end
                PH_W_PHI:   if (advance) phase_next = PH_W_PLO;
                PH_W_PLO:   if (advance) phase_next = PH_W_SDLY;
                PH_W_SDLY:  if (advance) phase_next = PH_W_ACK;
                PH_W_ACK:   if (advance) phase_next = PH_W_REL2;
                PH_W_REL2:  if (advance) phase_next = sub_phase;
                PH_R_DLY:   if (advance) phase_next = PH_R_FIRST;
                PH_R_FIRST: if (advance) phase_next = PH_R_DLY5;
                PH_R_DLY5:  if (advance) phase_next = PH_R_SHI;
                PH_R_SHI:   if (advance) phase_next = PH_R_BLO;
                PH_R_BLO:   if (advance) phase_next = PH_R_BHI;
                PH_R_BHI: begin
                    if (advance) phase_next = (bc_inc >= FRAME_BITS) ? PH_R_T0 : PH_R_BLO;
                end
                PH_R_T0:    if (advance) phase_next = PH_R_T1;
                PH_R_T1:    if (advance) phase_next = PH_R_T2;
                PH_R_T2:    if (advance) phase_next = PH_R_T3;
                PH_R_T3:    if (advance) phase_next = sub_phase;
                PH_I_DLY:   if (advance) phase_next = PH_IDLE;
                default:    phase_next = PH_IDLE;
            endcase
        end
    end

    // Datapath, drives and status.
    always_comb begin
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        parity_next    = parity_reg;
        init_step_next = init_step_reg;
        link_up_next   = link_up_reg;
        clk_low_next   = clk_low_reg;
        data_low_next  = data_low_reg;
        in_init_next   = in_init_reg;
        rx_hold_next   = rx_hold_reg;
        init_ok_next   = init_ok_reg;
        done_next      = 1'b0;

        if (abort_ev || (advance && !shared_tmr)) begin
            wait_timer_next = '0;
        end else if (is_delay || (is_wait && !wait_cond)) begin
            wait_timer_next = tmr_inc;
        end else begin
            wait_timer_next = wait_timer_reg;
        end

        if (abort_ev) begin
            if (rx_phase) rx_hold_next = '0;
            link_up_next = 1'b0;
            if (in_init_reg) init_ok_next = 1'b0;
            in_init_next = 1'b0;
            done_next    = 1'b1;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    if (item.mode == CMD_SEND || item.mode == CMD_INIT) begin
                        shift_next     = (item.mode == CMD_INIT) ? BYTE_RESET : item.tx_byte;
                        parity_next    = 1'b1;
                        bit_count_next = '0;
                        clk_low_next   = 1'b0;
                        data_low_next  = 1'b0;
                    end else if (item.mode == CMD_RECV) begin
                        shift_next     = '0;
                        bit_count_next = '0;
                        clk_low_next   = 1'b0;
                        data_low_next  = 1'b0;
                    end
                    if (item.mode == CMD_INIT) begin
                        link_up_next   = 1'b1;
                        init_ok_next   = 1'b0;
                        in_init_next   = 1'b1;
                        init_step_next = '0;
                    end
                end
                PH_W_REL:   if (advance) clk_low_next = 1'b1;
                PH_W_INH:   if (advance) data_low_next = 1'b1;
                PH_W_RTS:   if (advance) clk_low_next = 1'b0;
                PH_W_START: if (advance) data_low_next = !shift_reg[0];
                PH_W_BLO: begin
                    if (advance) begin
                        parity_next    = parity_new;
                        shift_next     = {1'b0, shift_reg[7:1]};
                        bit_count_next = bc_inc;
                        data_low_next  = (bc_inc >= FRAME_BITS) ? !parity_new : !shift_reg[1];
                    end
                end
                PH_W_PLO:   if (advance) data_low_next = 1'b0;
                PH_R_BLO: begin
                    if (advance && item.data_line) shift_next[bit_count_reg[2:0]] = 1'b1;
                end
                PH_R_BHI:   if (advance) bit_count_next = bc_inc;
                PH_R_T3:    if (advance) rx_hold_next = shift_reg;
                PH_I_DLY: begin
                    if (advance) begin
                        init_ok_next = 1'b1;
                        in_init_next = 1'b0;
                        done_next    = 1'b1;
                    end
                end
                PH_W_BHI, PH_W_PHI, PH_W_SDLY, PH_W_ACK, PH_W_REL2, PH_R_DLY,
                PH_R_FIRST, PH_R_DLY5, PH_R_SHI, PH_R_T0, PH_R_T1, PH_R_T2: ;
                default: begin
                    in_init_next = 1'b0;
                    done_next    = 1'b1;
                end
            endcase

            // End of a byte transfer: hold the clock low and finish, or move the init
            // sequence on; a further init transfer releases the clock again, the closing pause keeps it low.
            if (sub_done_ev) begin
                clk_low_next = 1'b1;
                if (!in_init_reg) begin
                    done_next = 1'b1;
                end else begin
                    init_step_next = init_inc;
                    if (init_inc == INIT_STEP_REMOTE) begin
                        shift_next     = BYTE_REMOTE;
                        parity_next    = 1'b1;
                        bit_count_next = '0;
                        clk_low_next   = 1'b0;
                        data_low_next  = 1'b0;
                    end else if (init_inc < INIT_STEP_PAUSE) begin
                        shift_next     = '0;
                        bit_count_next = '0;
                        clk_low_next   = 1'b0;
                        data_low_next  = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            shift_reg      <= '0;
            parity_reg     <= 1'b1;
            wait_timer_reg <= '0;
            init_step_reg  <= '0;
            link_up_reg    <= 1'b0;
            clk_low_reg    <= 1'b0;
            data_low_reg   <= 1'b0;
            in_init_reg    <= 1'b0;
            rx_hold_reg    <= '0;
            init_ok_reg    <= 1'b0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            parity_reg     <= parity_next;
            wait_timer_reg <= wait_timer_next;
            init_step_reg  <= init_step_next;
            link_up_reg    <= link_up_next;
            clk_low_reg    <= clk_low_next;
            data_low_reg   <= data_low_next;
            in_init_reg    <= in_init_next;
            rx_hold_reg    <= rx_hold_next;
            init_ok_reg    <= init_ok_next;
        end
    end

    always_comb begin
        result.clk_drive_low  = clk_low_next;
        result.data_drive_low = data_low_next;
        result.busy_res       = (phase_next != PH_IDLE);
        result.done_res       = done_next;
        result.rx_byte        = rx_hold_next;
        result.connected      = link_up_next;
        result.init_ok        = init_ok_next;
    end

endmodule

// ----- sv/ps2_host_transceiver.sv -----
// Channel   Direction  Payload
// s_axis    in         tuser[1:0] mode; tdata tx_byte, clk_line, data_line
// m_axis    out        tdata clk/data drives, busy, done, rx_byte, connected, init_ok
// apb       in/out     timeout_us at 0x0, inhibit_us at 0x4
//
// One result per request. A request waits in the input register and its result is
// written into the output register when it moves on; one request is taken every
// cycle while m_axis_tready stays high. The step logic updates the transfer state
// only when a request moves into the output register; a stall on m_axis holds the
// output register, and s_axis_tready drops once the input register is full.
// Reset is synchronous and active low and empties both registers.
module ps2_host_transceiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // tx_byte[7:0], clk_line[8], data_line[9], zero
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // clk_drive_low[0], data_drive_low[1], busy_res[2],
                                        // done_res[3], rx_byte[11:4], connected[12],
                                        // init_ok[13], zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ps2ht_pkg::*;

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic [15:0] timeout_reg;
    logic [11:0] inhibit_reg;
    logic        advance;
    logic        cfg_write;
    result_t     step_result;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg.mode      <= s_axis_tuser;
            in_item_reg.tx_byte   <= s_axis_tdata[7:0];
            in_item_reg.clk_line  <= s_axis_tdata[8];
            in_item_reg.data_line <= s_axis_tdata[9];
        end
    end

    ps2ht_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .item       (in_item_reg),
        .timeout_us (timeout_reg),
        .inhibit_us (inhibit_reg),
        .result     (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {2'b00, step_result};
        end
    end

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            inhibit_reg <= INHIBIT_RESET;
        end else if (cfg_write) begin
            case (reg_idx_t'(paddr[2]))
                REG_TIMEOUT: timeout_reg <= pwdata[15:0];
                REG_INHIBIT: inhibit_reg <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[2]))
            REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            REG_INHIBIT: prdata = {20'd0, inhibit_reg};
            default:     prdata = '0;
        endcase
    end

endmodule

// ----- sv/ps2ht_checker.sv -----
module ps2ht_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        pready
);

    // A finished or aborted command never reports itself as still running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
        else $error("done result still flagged busy");

    // With the output register empty nothing can hold back a new request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register is empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    assert property (@(posedge aclk) pready)
        else $error("configuration port not ready");

endmodule

bind ps2_host_transceiver ps2ht_checker u_ps2ht_checker (.*);
